FILE: hdl/arm_position_hold_controller_core_macros.svh
// Assertion macros used by the checker file of the arm position hold controller.
// Depends on nothing; the including module must provide clk_i and rst_ni.
`ifndef ARM_POSITION_HOLD_CONTROLLER_CORE_MACROS_SVH
`define ARM_POSITION_HOLD_CONTROLLER_CORE_MACROS_SVH

// Check a property on every rising edge outside reset.
`define APHC_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("aphc assertion failed");

// Check a property on every rising edge, reset included.
`define APHC_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("aphc assertion failed");

`endif

FILE: hdl/aphc_pkg.sv
// Types, constants and helper functions of the arm position hold controller.
// Used by the core and its checker; depends on nothing.
package aphc_pkg;

  localparam int unsigned POS_W   = 12;
  localparam int unsigned BAND_W  = 8;
  localparam int unsigned JUP_W   = 7;
  localparam int unsigned JDN_W   = 8;
  localparam int unsigned DRIVE_W = 9;
  localparam int unsigned GAIN_W  = 8;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;

  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [BAND_W-1:0]  band_t;
  typedef logic [JUP_W-1:0]   jog_up_t;
  typedef logic [JDN_W-1:0]   jog_dn_t;
  typedef logic [DRIVE_W-1:0] drive_t;
  typedef logic [GAIN_W-1:0]  gain_t;

  // Register map, word index into the APB window.
  typedef enum logic [2:0] {
    REG_LOWER_LIMIT    = 3'd0,
    REG_UPPER_LIMIT    = 3'd1,
    REG_HOLD_BAND      = 3'd2,
    REG_PRESET_FLIP    = 3'd3,
    REG_PRESET_UNDER   = 3'd4,
    REG_PRESET_DESCORE = 3'd5,
    REG_JOG_UP_DRIVE   = 3'd6,
    REG_JOG_DOWN_DRIVE = 3'd7
  } reg_idx_e;

  // Reset values.
  localparam pos_t    RST_LOWER_LIMIT    = 12'd700;
  localparam pos_t    RST_UPPER_LIMIT    = 12'd3200;
  localparam band_t   RST_HOLD_BAND      = 8'd16;
  localparam pos_t    RST_PRESET_FLIP    = 12'd1220;
  localparam pos_t    RST_PRESET_UNDER   = 12'd1800;
  localparam pos_t    RST_PRESET_DESCORE = 12'd2250;
  localparam jog_up_t RST_JOG_UP_DRIVE   = 7'd64;
  localparam jog_dn_t RST_JOG_DOWN_DRIVE = 8'd16;

  // Stepped hold gains and their distance thresholds.
  localparam gain_t GAIN_0 = 8'd8;
  localparam gain_t GAIN_1 = 8'd16;
  localparam gain_t GAIN_2 = 8'd32;
  localparam gain_t GAIN_3 = 8'd64;
  localparam gain_t GAIN_4 = 8'd128;
  localparam pos_t  DIST_0 = 12'd32;
  localparam pos_t  DIST_1 = 12'd64;
  localparam pos_t  DIST_2 = 12'd128;
  localparam pos_t  DIST_3 = 12'd256;

  function automatic gain_t hold_gain(pos_t dist_mag);
    gain_t g;
    if (dist_mag < DIST_0) begin
      g = GAIN_0;
    end else if (dist_mag < DIST_1) begin
      g = GAIN_1;
    end else if (dist_mag < DIST_2) begin
      g = GAIN_2;
    end else if (dist_mag < DIST_3) begin
      g = GAIN_3;
    end else begin
      g = GAIN_4;
    end
    return g;
  endfunction

endpackage

FILE: hdl/arm_position_hold_controller_core.sv
// Arm position hold controller: request register, one tick of control logic, result register.
// Depends on aphc_pkg.
//
// One request is one control tick: a 12-bit potentiometer sample plus the jog and
// preset buttons. Each request yields exactly one result: the signed motor drive,
// the hold flag and the hold target after that tick. The block takes one request
// per clock cycle while the output is not stalled; a request waits in the request
// register until it is processed, and its result is then registered in the result
// register and presented from there. The rate is set by the state update (target,
// hold flag, last drive), computed combinationally from the registered request and
// written as it is processed. The request register and the result register decouple the two sides, so
// a new request is taken while a finished result still waits; the input stalls only
// when both the request register and the result register are full and the output
// is stalled. Configuration goes through an APB-style port, one 32-bit word per
// register at byte address 4*index; write it only while no request is in flight.
module arm_position_hold_controller_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [aphc_pkg::POS_W-1:0]        arm_position_i,
  input  logic                              jog_up_i,
  input  logic                              jog_down_i,
  input  logic                              go_lowest_i,
  input  logic                              go_flip_i,
  input  logic                              go_under_i,
  input  logic                              go_descore_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [aphc_pkg::DRIVE_W-1:0] motor_drive_o,
  output logic                              hold_active_o,
  output logic [aphc_pkg::POS_W-1:0]        target_position_o,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [aphc_pkg::ADDR_W-1:0]       paddr,
  input  logic [aphc_pkg::DATA_W-1:0]       pwdata,
  output logic [aphc_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  aphc_pkg::pos_t    lower_limit_q, upper_limit_q;
  aphc_pkg::pos_t    preset_flip_q, preset_under_q, preset_descore_q;
  aphc_pkg::band_t   hold_band_q;
  aphc_pkg::jog_up_t jog_up_drive_q;
  aphc_pkg::jog_dn_t jog_down_drive_q;

  aphc_pkg::reg_idx_e reg_idx;
  logic               cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_idx   = aphc_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_limit_q    <= aphc_pkg::RST_LOWER_LIMIT;
      upper_limit_q    <= aphc_pkg::RST_UPPER_LIMIT;
      hold_band_q      <= aphc_pkg::RST_HOLD_BAND;
      preset_flip_q    <= aphc_pkg::RST_PRESET_FLIP;
      preset_under_q   <= aphc_pkg::RST_PRESET_UNDER;
      preset_descore_q <= aphc_pkg::RST_PRESET_DESCORE;
      jog_up_drive_q   <= aphc_pkg::RST_JOG_UP_DRIVE;
      jog_down_drive_q <= aphc_pkg::RST_JOG_DOWN_DRIVE;
    end else if (cfg_write) begin
      // Drop bits above each register's width.
      unique case (reg_idx)
        aphc_pkg::REG_LOWER_LIMIT:    lower_limit_q    <= pwdata[aphc_pkg::POS_W-1:0];
        aphc_pkg::REG_UPPER_LIMIT:    upper_limit_q    <= pwdata[aphc_pkg::POS_W-1:0];
        aphc_pkg::REG_HOLD_BAND:      hold_band_q      <= pwdata[aphc_pkg::BAND_W-1:0];
        aphc_pkg::REG_PRESET_FLIP:    preset_flip_q    <= pwdata[aphc_pkg::POS_W-1:0];
        aphc_pkg::REG_PRESET_UNDER:   preset_under_q   <= pwdata[aphc_pkg::POS_W-1:0];
        aphc_pkg::REG_PRESET_DESCORE: preset_descore_q <= pwdata[aphc_pkg::POS_W-1:0];
        aphc_pkg::REG_JOG_UP_DRIVE:   jog_up_drive_q   <= pwdata[aphc_pkg::JUP_W-1:0];
        aphc_pkg::REG_JOG_DOWN_DRIVE: jog_down_drive_q <= pwdata[aphc_pkg::JDN_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback, zero extended.
  always_comb begin
    unique case (reg_idx)
      aphc_pkg::REG_LOWER_LIMIT:    prdata = aphc_pkg::DATA_W'(lower_limit_q);
      aphc_pkg::REG_UPPER_LIMIT:    prdata = aphc_pkg::DATA_W'(upper_limit_q);
      aphc_pkg::REG_HOLD_BAND:      prdata = aphc_pkg::DATA_W'(hold_band_q);
      aphc_pkg::REG_PRESET_FLIP:    prdata = aphc_pkg::DATA_W'(preset_flip_q);
      aphc_pkg::REG_PRESET_UNDER:   prdata = aphc_pkg::DATA_W'(preset_under_q);
      aphc_pkg::REG_PRESET_DESCORE: prdata = aphc_pkg::DATA_W'(preset_descore_q);
      aphc_pkg::REG_JOG_UP_DRIVE:   prdata = aphc_pkg::DATA_W'(jog_up_drive_q);
      aphc_pkg::REG_JOG_DOWN_DRIVE: prdata = aphc_pkg::DATA_W'(jog_down_drive_q);
      default:                      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Request register
  // ---------------------------------------------------------------------------
  logic           req_valid_q;
  aphc_pkg::pos_t pos_q;
  logic           jog_up_q, jog_down_q;
  logic           go_lowest_q, go_flip_q, go_under_q, go_descore_q;

  logic out_valid_q;
  logic req_take;   // request accepted into the request register
  logic advance;    // registered request is processed this cycle

  assign advance    = req_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = req_valid_q && !advance;
  assign req_take   = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (req_take) begin
      req_valid_q <= 1'b1;
    end else if (advance) begin
      req_valid_q <= 1'b0;
    end
  end

  // Payload holds without reset; loaded only on accept.
  always_ff @(posedge clk_i) begin
    if (req_take) begin
      pos_q        <= arm_position_i;
      jog_up_q     <= jog_up_i;
      jog_down_q   <= jog_down_i;
      go_lowest_q  <= go_lowest_i;
      go_flip_q    <= go_flip_i;
      go_under_q   <= go_under_i;
      go_descore_q <= go_descore_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Tick logic: hold phase, jog phase, preset phase
  // ---------------------------------------------------------------------------
  aphc_pkg::pos_t   target_q, target_d;
  logic             holding_q, holding_d;
  aphc_pkg::drive_t drive_q, drive_d;

  aphc_pkg::pos_t   dist_mag;
  aphc_pkg::gain_t  gain;
  logic [aphc_pkg::POS_W:0] pos_plus_band, tgt_plus_band;
  logic             below_band, above_band;
  logic             outside_limits;
  logic             jog_down_ok, jog_up_ok;
  aphc_pkg::drive_t hold_drive;

  always_comb begin
    dist_mag = (pos_q > target_q) ? (pos_q - target_q) : (target_q - pos_q);
    gain     = aphc_pkg::hold_gain(dist_mag);

    // pos < tgt - band  <=>  pos + band < tgt, kept unsigned at one extra bit.
    pos_plus_band = {1'b0, pos_q} + (aphc_pkg::POS_W + 1)'(hold_band_q);
    tgt_plus_band = {1'b0, target_q} + (aphc_pkg::POS_W + 1)'(hold_band_q);
    below_band    = pos_plus_band < {1'b0, target_q};
    above_band    = {1'b0, pos_q} > tgt_plus_band;

    outside_limits = (pos_q > upper_limit_q) || (pos_q < lower_limit_q);
    jog_down_ok    = jog_down_q && (pos_q > lower_limit_q);
    jog_up_ok      = jog_up_q && (pos_q < upper_limit_q);

    // Hold phase.
    priority if (below_band) begin
      hold_drive = aphc_pkg::DRIVE_W'(gain);
    end else if (above_band) begin
      hold_drive = aphc_pkg::drive_t'(0) - aphc_pkg::DRIVE_W'(gain);
    end else begin
      hold_drive = '0;
    end

    target_d  = target_q;
    holding_d = holding_q;
    if (holding_q) begin
      drive_d = hold_drive;
    end else if (outside_limits) begin
      drive_d = '0;
    end else begin
      drive_d = drive_q;
    end

    // Jog phase: down wins over up; release re-arms hold at the sample.
    priority if (jog_down_ok) begin
      holding_d = 1'b0;
      drive_d   = aphc_pkg::drive_t'(0) - aphc_pkg::DRIVE_W'(jog_down_drive_q);
    end else if (jog_up_ok) begin
      holding_d = 1'b0;
      drive_d   = aphc_pkg::DRIVE_W'(jog_up_drive_q);
    end else if (!holding_q) begin
      holding_d = 1'b1;
      drive_d   = '0;
      target_d  = pos_q;
    end

    // Preset phase, lowest preset first.
    priority if (go_lowest_q) begin
      target_d = lower_limit_q;
    end else if (go_flip_q) begin
      target_d = preset_flip_q;
    end else if (go_under_q) begin
      target_d = preset_under_q;
    end else if (go_descore_q) begin
      target_d = preset_descore_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q  <= aphc_pkg::RST_LOWER_LIMIT;
      holding_q <= 1'b1;
      drive_q   <= '0;
    end else if (advance) begin
      target_q  <= target_d;
      holding_q <= holding_d;
      drive_q   <= drive_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  aphc_pkg::drive_t res_drive_q;
  logic             res_hold_q;
  aphc_pkg::pos_t   res_target_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_drive_q  <= drive_d;
      res_hold_q   <= holding_d;
      res_target_q <= target_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign motor_drive_o     = $signed(res_drive_q);
  assign hold_active_o     = res_hold_q;
  assign target_position_o = res_target_q;

endmodule

FILE: hdl/aphc_checker.sv
// Port-level checker for the arm position hold controller, bound to the core.
// Depends on aphc_pkg and arm_position_hold_controller_core_macros.svh.
`include "arm_position_hold_controller_core_macros.svh"

module aphc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [aphc_pkg::DRIVE_W-1:0] motor_drive_o,
  input logic                              hold_active_o,
  input logic [aphc_pkg::POS_W-1:0]        target_position_o
);

  logic [aphc_pkg::DRIVE_W-1:0] drv;
  logic [aphc_pkg::DRIVE_W-1:0] zero;
  assign drv  = motor_drive_o;
  assign zero = '0;

  // Stalled result holds.
  `APHC_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(motor_drive_o) && $stable(hold_active_o) && $stable(target_position_o))

  // Input stalls only behind a stalled, full output.
  `APHC_ASSERT_ALWAYS(a_stall_cause, in_stall_o |-> out_valid_o && out_stall_i)

  // An accepted request reaches the output through the result register when the output is not stalled.
  `APHC_ASSERT(a_latency, (in_valid_i && !in_stall_o) ##1 !out_stall_i |=> out_valid_o)

  // While holding, the drive is zero or plus or minus one of the stepped gains.
  `APHC_ASSERT(a_hold_drive, out_valid_o && hold_active_o |-> drv == zero || drv == aphc_pkg::DRIVE_W'(aphc_pkg::GAIN_0) || drv == aphc_pkg::DRIVE_W'(aphc_pkg::GAIN_1) || drv == aphc_pkg::DRIVE_W'(aphc_pkg::GAIN_2) || drv == aphc_pkg::DRIVE_W'(aphc_pkg::GAIN_3) || drv == aphc_pkg::DRIVE_W'(aphc_pkg::GAIN_4) || drv == zero - aphc_pkg::DRIVE_W'(aphc_pkg::GAIN_0) || drv == zero - aphc_pkg::DRIVE_W'(aphc_pkg::GAIN_1) || drv == zero - aphc_pkg::DRIVE_W'(aphc_pkg::GAIN_2) || drv == zero - aphc_pkg::DRIVE_W'(aphc_pkg::GAIN_3) || drv == zero - aphc_pkg::DRIVE_W'(aphc_pkg::GAIN_4))

endmodule

bind arm_position_hold_controller_core aphc_checker u_aphc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .motor_drive_o     (motor_drive_o),
  .hold_active_o     (hold_active_o),
  .target_position_o (target_position_o)
);

FILE: verif/tb.sv
// Self-checking testbench for arm_position_hold_controller_core: control ticks, APB
// register settings and random traffic, checked against a predictor held in the bench.
// Depends on aphc_pkg and the core RTL.
module tb;

  localparam int CYCLE_LIMIT = 200000;

  // One control tick as the request channel carries it.
  typedef struct packed {
    aphc_pkg::pos_t arm_position;
    logic           jog_up;
    logic           jog_down;
    logic           go_lowest;
    logic           go_flip;
    logic           go_under;
    logic           go_descore;
  } tick_t;

  // The arm command that one tick yields.
  typedef struct packed {
    aphc_pkg::drive_t motor_drive;
    logic             hold_active;
    aphc_pkg::pos_t   target_position;
  } arm_cmd_t;

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  tick_t                               req = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic signed [aphc_pkg::DRIVE_W-1:0] motor_drive;
  logic                                hold_active;
  aphc_pkg::pos_t                      target_position;
  logic                                psel = 1'b0;
  logic                                penable = 1'b0;
  logic                                pwrite = 1'b0;
  logic [aphc_pkg::ADDR_W-1:0]         paddr = '0;
  logic [aphc_pkg::DATA_W-1:0]         pwdata = '0;
  logic [aphc_pkg::DATA_W-1:0]         prdata;
  logic                                pready;

  arm_position_hold_controller_core u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .arm_position_i    (req.arm_position),
    .jog_up_i          (req.jog_up),
    .jog_down_i        (req.jog_down),
    .go_lowest_i       (req.go_lowest),
    .go_flip_i         (req.go_flip),
    .go_under_i        (req.go_under),
    .go_descore_i      (req.go_descore),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .motor_drive_o     (motor_drive),
    .hold_active_o     (hold_active),
    .target_position_o (target_position),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor copy of the registers.
  aphc_pkg::pos_t    cfg_lower    = aphc_pkg::RST_LOWER_LIMIT;
  aphc_pkg::pos_t    cfg_upper    = aphc_pkg::RST_UPPER_LIMIT;
  aphc_pkg::band_t   cfg_band     = aphc_pkg::RST_HOLD_BAND;
  aphc_pkg::pos_t    cfg_flip     = aphc_pkg::RST_PRESET_FLIP;
  aphc_pkg::pos_t    cfg_under    = aphc_pkg::RST_PRESET_UNDER;
  aphc_pkg::pos_t    cfg_descore  = aphc_pkg::RST_PRESET_DESCORE;
  aphc_pkg::jog_up_t cfg_jog_up   = aphc_pkg::RST_JOG_UP_DRIVE;
  aphc_pkg::jog_dn_t cfg_jog_down = aphc_pkg::RST_JOG_DOWN_DRIVE;

  // Predictor copy of the controller state.
  aphc_pkg::pos_t hold_target = aphc_pkg::RST_LOWER_LIMIT;
  bit             hold_on     = 1'b1;
  int             drive_now   = 0;

  arm_cmd_t expected_cmds[$];
  int       mismatch_count = 0;
  int       cycle = 0;

  // Traffic shaping, owned by the test tasks.
  int idle_pct       = 0;
  int stall_pct      = 0;
  int hold_off_until = 0;

  // Jog run in progress for the random stimulus.
  int jog_run_left = 0;
  int jog_run_dir  = 0;

  // Advance the controller by one tick and return the command it would issue.
  function automatic arm_cmd_t predict_tick(tick_t t);
    int pos, lo, hi, tgt, band, dist_mag, gain;
    arm_cmd_t r;
    pos = int'(t.arm_position);
    lo  = int'(cfg_lower);
    hi  = int'(cfg_upper);

    // Hold phase: stepped gain toward the target outside the dead band.
    if (hold_on) begin
      tgt      = int'(hold_target);
      band     = int'(cfg_band);
      dist_mag = (pos > tgt) ? pos - tgt : tgt - pos;
      if (dist_mag < int'(aphc_pkg::DIST_0)) begin
        gain = int'(aphc_pkg::GAIN_0);
      end else if (dist_mag < int'(aphc_pkg::DIST_1)) begin
        gain = int'(aphc_pkg::GAIN_1);
      end else if (dist_mag < int'(aphc_pkg::DIST_2)) begin
        gain = int'(aphc_pkg::GAIN_2);
      end else if (dist_mag < int'(aphc_pkg::DIST_3)) begin
        gain = int'(aphc_pkg::GAIN_3);
      end else begin
        gain = int'(aphc_pkg::GAIN_4);
      end
      if (pos < tgt - band) begin
        drive_now = gain;
      end else if (pos > tgt + band) begin
        drive_now = -gain;
      end else begin
        drive_now = 0;
      end
    end else if (pos > hi || pos < lo) begin
      drive_now = 0;
    end

    // Jog phase: down wins over up; a released or blocked jog re-arms hold here.
    if (t.jog_down && pos > lo) begin
      hold_on   = 1'b0;
      drive_now = -int'(cfg_jog_down);
    end else if (t.jog_up && pos < hi) begin
      hold_on   = 1'b0;
      drive_now = int'(cfg_jog_up);
    end else if (!hold_on) begin
      hold_on     = 1'b1;
      drive_now   = 0;
      hold_target = t.arm_position;
    end

    // Preset phase: lowest preset first.
    if (t.go_lowest) begin
      hold_target = cfg_lower;
    end else if (t.go_flip) begin
      hold_target = cfg_flip;
    end else if (t.go_under) begin
      hold_target = cfg_under;
    end else if (t.go_descore) begin
      hold_target = cfg_descore;
    end

    r.motor_drive     = aphc_pkg::drive_t'(drive_now);
    r.hold_active     = hold_on;
    r.target_position = hold_target;
    return r;
  endfunction

  function automatic logic [aphc_pkg::DATA_W-1:0] reg_value(aphc_pkg::reg_idx_e idx);
    logic [aphc_pkg::DATA_W-1:0] v;
    case (idx)
      aphc_pkg::REG_LOWER_LIMIT:    v = aphc_pkg::DATA_W'(cfg_lower);
      aphc_pkg::REG_UPPER_LIMIT:    v = aphc_pkg::DATA_W'(cfg_upper);
      aphc_pkg::REG_HOLD_BAND:      v = aphc_pkg::DATA_W'(cfg_band);
      aphc_pkg::REG_PRESET_FLIP:    v = aphc_pkg::DATA_W'(cfg_flip);
      aphc_pkg::REG_PRESET_UNDER:   v = aphc_pkg::DATA_W'(cfg_under);
      aphc_pkg::REG_PRESET_DESCORE: v = aphc_pkg::DATA_W'(cfg_descore);
      aphc_pkg::REG_JOG_UP_DRIVE:   v = aphc_pkg::DATA_W'(cfg_jog_up);
      default:                      v = aphc_pkg::DATA_W'(cfg_jog_down);
    endcase
    return v;
  endfunction

  function automatic tick_t make_tick(int pos, bit up, bit down, logic [3:0] presets);
    tick_t t;
    t.arm_position = aphc_pkg::pos_t'(pos);
    t.jog_up       = up;
    t.jog_down     = down;
    t.go_lowest    = presets[3];
    t.go_flip      = presets[2];
    t.go_under     = presets[1];
    t.go_descore   = presets[0];
    return t;
  endfunction

  // Random tick, steered toward the hold target and the limits so that every
  // gain step, the dead band edges and the jog blocks get exercised.
  function automatic tick_t random_tick();
    tick_t t;
    int pos, sel, mag;
    sel = $urandom_range(99);
    if (sel < 40) begin
      mag = ($urandom_range(3) == 0) ? $urandom_range(300) : $urandom_range(40);
      pos = $urandom_range(1) ? int'(hold_target) + mag : int'(hold_target) - mag;
    end else if (sel < 60) begin
      pos = $urandom_range(1) ? int'(cfg_lower) : int'(cfg_upper);
      pos = pos + $urandom_range(6) - 3;
    end else begin
      pos = $urandom_range(4095);
    end
    if (pos < 0) pos = 0;
    if (pos > 4095) pos = 4095;
    t.arm_position = aphc_pkg::pos_t'(pos);

    // Mostly held jog runs of a few ticks, with some noise on the buttons.
    if (jog_run_left == 0 && $urandom_range(99) < 10) begin
      jog_run_left = $urandom_range(8, 1);
      jog_run_dir  = $urandom_range(2);
    end
    if (jog_run_left > 0) begin
      jog_run_left--;
      t.jog_up   = (jog_run_dir != 1);
      t.jog_down = (jog_run_dir != 0);
    end else begin
      t.jog_up   = ($urandom_range(99) < 4);
      t.jog_down = ($urandom_range(99) < 4);
    end
    t.go_lowest  = ($urandom_range(99) < 6);
    t.go_flip    = ($urandom_range(99) < 6);
    t.go_under   = ($urandom_range(99) < 6);
    t.go_descore = ($urandom_range(99) < 6);
    return t;
  endfunction

  // Record the expected command for every request the block takes.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid && !in_stall) begin
      expected_cmds.push_back(predict_tick(req));
    end
  end

  // Compare every accepted result with the oldest expected command.
  always @(posedge clk_i) begin : check_results
    arm_cmd_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_cmds.size() == 0) begin
        $error("result with no request pending");
        mismatch_count++;
      end else begin
        want = expected_cmds.pop_front();
        if (motor_drive !== want.motor_drive) begin
          $error("motor_drive: expected %0d, got %0d",
                 $signed(want.motor_drive), $signed(motor_drive));
          mismatch_count++;
        end
        if (hold_active !== want.hold_active) begin
          $error("hold_active: expected %0d, got %0d", want.hold_active, hold_active);
          mismatch_count++;
        end
        if (target_position !== want.target_position) begin
          $error("target_position: expected %0d, got %0d",
                 want.target_position, target_position);
          mismatch_count++;
        end
      end
    end
  end

  // Receiver: random stalls, plus a forced hold-off window set by the tests.
  always @(posedge clk_i) begin
    if (cycle < hold_off_until) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Cycle count and watchdog.
  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (cycle >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Offer one request, idling first at random; hold the payload while stalled.
  task automatic send_tick(tick_t t);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    req      <= t;
    do @(posedge clk_i); while (in_stall);
  endtask

  // Drop valid and wait until every expected command has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (expected_cmds.size() != 0);
  endtask

  // APB write, then read the register back; bits above its width drop off.
  task automatic write_reg(aphc_pkg::reg_idx_e idx, logic [aphc_pkg::DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      aphc_pkg::REG_LOWER_LIMIT:    cfg_lower    = data[aphc_pkg::POS_W-1:0];
      aphc_pkg::REG_UPPER_LIMIT:    cfg_upper    = data[aphc_pkg::POS_W-1:0];
      aphc_pkg::REG_HOLD_BAND:      cfg_band     = data[aphc_pkg::BAND_W-1:0];
      aphc_pkg::REG_PRESET_FLIP:    cfg_flip     = data[aphc_pkg::POS_W-1:0];
      aphc_pkg::REG_PRESET_UNDER:   cfg_under    = data[aphc_pkg::POS_W-1:0];
      aphc_pkg::REG_PRESET_DESCORE: cfg_descore  = data[aphc_pkg::POS_W-1:0];
      aphc_pkg::REG_JOG_UP_DRIVE:   cfg_jog_up   = data[aphc_pkg::JUP_W-1:0];
      default:                      cfg_jog_down = data[aphc_pkg::JDN_W-1:0];
    endcase
    @(posedge clk_i);
    psel    <= 1'b1;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== reg_value(idx)) begin
      $error("prdata: expected %0d, got %0d", reg_value(idx), prdata);
      mismatch_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_all(int lo, int hi, int band, int flip, int under, int descore,
                           int jup, int jdn);
    write_reg(aphc_pkg::REG_LOWER_LIMIT,    aphc_pkg::DATA_W'(lo));
    write_reg(aphc_pkg::REG_UPPER_LIMIT,    aphc_pkg::DATA_W'(hi));
    write_reg(aphc_pkg::REG_HOLD_BAND,      aphc_pkg::DATA_W'(band));
    write_reg(aphc_pkg::REG_PRESET_FLIP,    aphc_pkg::DATA_W'(flip));
    write_reg(aphc_pkg::REG_PRESET_UNDER,   aphc_pkg::DATA_W'(under));
    write_reg(aphc_pkg::REG_PRESET_DESCORE, aphc_pkg::DATA_W'(descore));
    write_reg(aphc_pkg::REG_JOG_UP_DRIVE,   aphc_pkg::DATA_W'(jup));
    write_reg(aphc_pkg::REG_JOG_DOWN_DRIVE, aphc_pkg::DATA_W'(jdn));
  endtask

  task automatic send_random(int count);
    repeat (count) send_tick(random_tick());
  endtask

  // Reset settings, target 700, band 16: walk the gain steps and band edges,
  // the jog blocks at the limits, both jogs, re-arm on release and presets.
  task automatic test_directed_ticks();
    idle_pct  = 10;
    stall_pct = 10;
    send_tick(make_tick(700,  0, 0, 4'b0000));  // on target
    send_tick(make_tick(716,  0, 0, 4'b0000));  // upper band edge
    send_tick(make_tick(717,  0, 0, 4'b0000));  // just above band
    send_tick(make_tick(684,  0, 0, 4'b0000));  // lower band edge
    send_tick(make_tick(683,  0, 0, 4'b0000));  // just below band
    send_tick(make_tick(731,  0, 0, 4'b0000));
    send_tick(make_tick(732,  0, 0, 4'b0000));
    send_tick(make_tick(764,  0, 0, 4'b0000));
    send_tick(make_tick(828,  0, 0, 4'b0000));
    send_tick(make_tick(955,  0, 0, 4'b0000));
    send_tick(make_tick(956,  0, 0, 4'b0000));
    send_tick(make_tick(0,    0, 0, 4'b0000));  // sample extremes
    send_tick(make_tick(4095, 0, 0, 4'b0000));
    send_tick(make_tick(700,  0, 1, 4'b0000));  // jog down blocked at lower limit
    send_tick(make_tick(701,  0, 1, 4'b0000));  // jog down drops hold
    send_tick(make_tick(4095, 0, 0, 4'b0000));  // released outside limits
    send_tick(make_tick(3200, 1, 0, 4'b0000));  // jog up blocked at upper limit
    send_tick(make_tick(3199, 1, 0, 4'b0000));  // jog up drops hold
    send_tick(make_tick(2000, 1, 1, 4'b0000));  // both jogs: down first
    send_tick(make_tick(700,  1, 1, 4'b0000));  // down blocked, up takes over
    send_tick(make_tick(1500, 0, 0, 4'b0000));  // release re-arms at sample
    send_tick(make_tick(1500, 0, 0, 4'b0001));
    send_tick(make_tick(1500, 0, 0, 4'b0010));
    send_tick(make_tick(1500, 0, 0, 4'b0100));
    send_tick(make_tick(1500, 0, 0, 4'b1000));
    send_tick(make_tick(2000, 0, 1, 4'b1111));  // jog plus every preset
    send_tick(make_tick(2000, 0, 0, 4'b0111));  // release and preset together
    wait_drained();
  endtask

  // Several register settings, the extremes and crossed limits among them.
  task automatic test_register_settings();
    idle_pct  = 10;
    stall_pct = 10;
    write_all(0, 4095, 0, 0, 4095, 2048, 127, 128);
    send_random(60);
    wait_drained();
    write_all(4095, 0, 255, 4095, 0, 1, 0, 0);      // lower above upper
    send_random(60);
    wait_drained();
    write_all(1000, 3000, 1, 1000, 3000, 2000, 1, 1);
    send_random(60);
    wait_drained();
    // Upper bits set: only the low bits of each register may stick.
    write_reg(aphc_pkg::REG_LOWER_LIMIT,    32'hFFFF_F2A5);
    write_reg(aphc_pkg::REG_UPPER_LIMIT,    32'h8000_3C10);
    write_reg(aphc_pkg::REG_HOLD_BAND,      32'hFFFF_FF20);
    write_reg(aphc_pkg::REG_PRESET_FLIP,    32'hAAAA_A555);
    write_reg(aphc_pkg::REG_PRESET_UNDER,   32'h5555_5AAA);
    write_reg(aphc_pkg::REG_PRESET_DESCORE, 32'hFFFF_F800);
    write_reg(aphc_pkg::REG_JOG_UP_DRIVE,   32'hFFFF_FFFF);
    write_reg(aphc_pkg::REG_JOG_DOWN_DRIVE, 32'hFFFF_FF80);
    send_random(60);
    wait_drained();
    repeat (2) begin
      write_all($urandom_range(4095), $urandom_range(4095), $urandom_range(255),
                $urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                $urandom_range(127), $urandom_range(128));
      send_random(60);
      wait_drained();
    end
    write_all(aphc_pkg::RST_LOWER_LIMIT, aphc_pkg::RST_UPPER_LIMIT,
              aphc_pkg::RST_HOLD_BAND, aphc_pkg::RST_PRESET_FLIP,
              aphc_pkg::RST_PRESET_UNDER, aphc_pkg::RST_PRESET_DESCORE,
              aphc_pkg::RST_JOG_UP_DRIVE, aphc_pkg::RST_JOG_DOWN_DRIVE);
  endtask

  // Bulk random traffic through phases of sender idling and receiver stalls, on a typical setting.
  task automatic test_random_traffic();
    write_all(600, 3400, 12, 1100, 1900, 2600, 90, 100);
    idle_pct  = 0;
    stall_pct = 0;
    send_random(300);
    idle_pct  = 72;
    stall_pct = 0;
    send_random(300);
    idle_pct  = 0;
    stall_pct = 72;
    send_random(300);
    idle_pct  = 10;
    stall_pct = 10;
    send_random(300);
    wait_drained();
  endtask

  // Hold the receiver off while requests keep coming so the input stalls, then pause
  // the sender until everything is back; repeat with random receiver stalls.
  task automatic test_backpressure();
    idle_pct       = 0;
    stall_pct      = 0;
    hold_off_until = cycle + 80;
    send_random(40);
    wait_drained();
    stall_pct = 30;
    send_random(20);
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_ticks();
    test_register_settings();
    test_random_traffic();
    test_backpressure();

    wait_drained();
    repeat (6) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
